// ===== rtl/tcc_pkg.sv =====
// Shared types and constants of the text console cursor engine.
package tcc_pkg;

  localparam int unsigned MAX_CELLS_DEF = 4096;
  localparam int unsigned CNT_W = 17;
  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [3:0] WHITE = 4'hF;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_BUFFER_ROWS = 2'd1;
  localparam logic [1:0] CFG_VISIBLE_ROWS = 2'd2;

  typedef enum logic [2:0] {
    OP_PUT_ADV = 3'd0,
    OP_PUT = 3'd1,
    OP_SET = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PUT,
    WR_INIT,
    WR_CLEAR,
    WR_COPY,
    WR_ZERO
  } wr_sel_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CELL,
    RD_SCROLL
  } rd_sel_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_SET,
    CUR_COL_INC,
    CUR_NEXT_ROW,
    CUR_COL_ZERO
  } cur_sel_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  character;
    logic [3:0]  background;
    logic [3:0]  foreground;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [11:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [7:0]  cursor_column;
    logic [7:0]  cursor_row;
    logic [11:0] viewport_start;
    logic [15:0] read_data;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     cnt_clr;
    logic     cnt_inc;
    wr_sel_e  wr_sel;
    rd_sel_e  rd_sel;
    cur_sel_e cur_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic newline;
    logic col_wrap;
    logic row_last;
    logic keep_done;
    logic clr_done;
    logic zero_done;
    logic init_done;
  } sts_t;

endpackage

// ===== rtl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine.
//
// channel  direction  handshake                   word
// in       input      in_valid_i / in_stall_o     in_word_i  (tcc_pkg::in_t)
// out      output     out_valid_o / out_stall_i   out_word_o (tcc_pkg::out_t)
// cfg      input      cfg_we_i                    cfg_index_i, cfg_data_i
//
// Put, set cursor and read pass through the execute and finish states from accept to result.
// Clear writes visible_rows*columns cells, one cell written per cycle.
// Scroll copies (buffer_rows-1)*columns cells, each read then written, as the store has one read port.
// After reset a clearing pass blanks all MAX_CELLS cells of the store; in_stall_o stays high.
// A finished result waits in the output register while out_stall_i is high.
module text_console_cursor_engine #(
  parameter int unsigned MAX_CELLS = tcc_pkg::MAX_CELLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tcc_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tcc_pkg::out_t out_word_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);
  import tcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcc_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/tcc_dp.sv =====
// Datapath: cell store, cursor, geometry registers, sweep counter and result register.
module tcc_dp #(
  parameter int unsigned MAX_CELLS = tcc_pkg::MAX_CELLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcc_pkg::in_t  in_word_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  tcc_pkg::cmd_t cmd_i,
  output tcc_pkg::sts_t sts_o,
  output tcc_pkg::out_t out_word_o
);
  import tcc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_CELLS);

  logic [15:0] mem [MAX_CELLS];

  in_t              in_q;
  logic [7:0]       columns_q, buffer_rows_q, visible_rows_q;
  logic [7:0]       col_q, row_q;
  logic [CNT_W-1:0] cnt_q;
  logic [15:0]      rdata_q;
  logic             rd_ok_q;
  out_t             out_q;

  logic [7:0]       cols_e, rows_e, vis_e;
  logic [15:0]      put_prod, keep, n_clr, view_prod;
  logic [CNT_W-1:0] put_addr, waddr, raddr, cnt_nx;
  logic [15:0]      wdata;
  logic             we, rd_en;
  logic [7:0]       row_diff;

  assign cols_e = (columns_q == 8'd0) ? 8'd1 : columns_q;
  assign rows_e = (buffer_rows_q == 8'd0) ? 8'd1 : buffer_rows_q;
  assign vis_e  = (visible_rows_q == 8'd0) ? 8'd1 : visible_rows_q;

  assign put_prod  = 16'(row_q) * 16'(cols_e);
  assign put_addr  = CNT_W'(put_prod) + CNT_W'(col_q);
  assign keep      = 16'(rows_e - 8'd1) * 16'(cols_e);
  assign n_clr     = 16'(vis_e) * 16'(cols_e);
  assign row_diff  = row_q - vis_e;
  assign view_prod = 16'(row_diff) * 16'(cols_e);
  assign cnt_nx    = cnt_q + CNT_W'(1);

  always_comb begin
    waddr = cnt_q;
    wdata = 16'h0000;
    case (cmd_i.wr_sel)
      WR_PUT: begin
        waddr = put_addr;
        wdata = {in_q.background, in_q.foreground, in_q.character};
      end
      WR_INIT:  wdata = BLANK_CELL;
      WR_CLEAR: wdata = {in_q.background, WHITE, SPACE_CHAR};
      WR_COPY:  wdata = rd_ok_q ? rdata_q : 16'h0000;
      WR_ZERO:  waddr = CNT_W'(keep) + cnt_q;
      default:  waddr = cnt_q;
    endcase
  end

  assign we = (cmd_i.wr_sel != WR_NONE) && (waddr < MAX_C);

  always_comb begin
    raddr = CNT_W'(in_q.cell_index);
    if (cmd_i.rd_sel == RD_SCROLL) begin
      raddr = cnt_q + CNT_W'(cols_e);
    end
  end

  assign rd_en = cmd_i.rd_sel != RD_NONE;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr[AW-1:0]];
      rd_ok_q <= raddr < MAX_C;
    end
    if (cmd_i.load) begin
      in_q <= in_word_i;
    end
    if (cmd_i.out_load) begin
      out_q.cursor_column  <= col_q;
      out_q.cursor_row     <= row_q;
      out_q.viewport_start <= (row_q >= vis_e) ? view_prod[11:0] : 12'd0;
      out_q.read_data      <= (op_e'(in_q.operation) == OP_READ && rd_ok_q) ? rdata_q : 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q      <= 8'd80;
      buffer_rows_q  <= 8'd25;
      visible_rows_q <= 8'd25;
      col_q          <= 8'd0;
      row_q          <= 8'd0;
      cnt_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMNS:      columns_q <= cfg_data_i;
          CFG_BUFFER_ROWS:  buffer_rows_q <= cfg_data_i;
          CFG_VISIBLE_ROWS: visible_rows_q <= cfg_data_i;
          default:          columns_q <= columns_q;
        endcase
      end
      case (cmd_i.cur_sel)
        CUR_SET: begin
          col_q <= in_q.column;
          row_q <= in_q.row;
        end
        CUR_COL_INC: col_q <= col_q + 8'd1;
        CUR_NEXT_ROW: begin
          col_q <= 8'd0;
          row_q <= row_q + 8'd1;
        end
        CUR_COL_ZERO: col_q <= 8'd0;
        default: col_q <= col_q;
      endcase
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_nx;
      end
    end
  end

  assign sts_o.op        = op_e'(in_q.operation);
  assign sts_o.newline   = in_q.character == NEWLINE_CHAR;
  assign sts_o.col_wrap  = ({1'b0, col_q} + 9'd1) >= {1'b0, cols_e};
  assign sts_o.row_last  = ({1'b0, row_q} + 9'd1) >= {1'b0, rows_e};
  assign sts_o.keep_done = cnt_q >= CNT_W'(keep);
  assign sts_o.clr_done  = cnt_nx >= CNT_W'(n_clr);
  assign sts_o.zero_done = cnt_nx >= CNT_W'(cols_e);
  assign sts_o.init_done = cnt_q == MAX_C - CNT_W'(1);

  assign out_word_o = out_q;

endmodule

// ===== rtl/tcc_ctrl.sv =====
// Controller: sequences operations, store sweeps and the result handshake.
module tcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  tcc_pkg::sts_t sts_i,
  output tcc_pkg::cmd_t cmd_o
);
  import tcc_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SC_RD,
    S_SC_WR,
    S_SC_ZERO,
    S_CLR,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, slot_free;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.load  = accept;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_INIT: begin
        cmd_o.wr_sel  = WR_INIT;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.init_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        unique case (sts_i.op)
          OP_PUT_ADV: begin
            if (!sts_i.newline) begin
              cmd_o.wr_sel = WR_PUT;
            end
            if (sts_i.newline || sts_i.col_wrap) begin
              if (sts_i.row_last) begin
                cmd_o.cur_sel = CUR_COL_ZERO;
                cmd_o.cnt_clr = 1'b1;
                state_d       = S_SC_RD;
              end else begin
                cmd_o.cur_sel = CUR_NEXT_ROW;
              end
            end else begin
              cmd_o.cur_sel = CUR_COL_INC;
            end
          end
          OP_PUT:   cmd_o.wr_sel = WR_PUT;
          OP_SET:   cmd_o.cur_sel = CUR_SET;
          OP_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_CLR;
          end
          OP_READ:  cmd_o.rd_sel = RD_CELL;
          default:  state_d = S_FIN;
        endcase
      end
      S_SC_RD: begin
        if (sts_i.keep_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_SC_ZERO;
        end else begin
          cmd_o.rd_sel = RD_SCROLL;
          state_d      = S_SC_WR;
        end
      end
      S_SC_WR: begin
        cmd_o.wr_sel  = WR_COPY;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_SC_RD;
      end
      S_SC_ZERO: begin
        cmd_o.wr_sel  = WR_ZERO;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.zero_done) begin
          state_d = S_FIN;
        end
      end
      S_CLR: begin
        cmd_o.wr_sel  = WR_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> slot_free)
    else $error("result loaded over a waiting word");

  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> in_stall_o)
    else $error("word accepted during store clearing");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted word not executed");

endmodule

// ===== verif/tb_text_console_cursor_engine.sv =====
// Self-checking testbench of the text console cursor engine: random and directed words.
`timescale 1ns / 1ps
module tb_text_console_cursor_engine;
  import tcc_pkg::*;

  localparam int unsigned CELLS = 4096;
  localparam int IN_W = $bits(in_t);

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_t        in_word_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_word_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  text_console_cursor_engine dut (.*);

  always #10 clk_i = ~clk_i;

  logic [15:0] screen [CELLS];
  logic [7:0]  cur_col, cur_row, ncols, nbuf, nvis;
  in_t         pending_words [$];
  out_t        expected_words [$];
  int          send_idle_pct = 0, recv_idle_pct = 0;
  bit          failed = 1'b0;
  bit          hold_send = 1'b0;
  bit          in_taken = 1'b0;
  logic [7:0]  cfg_sets [6][3] = '{
    '{8'd80, 8'd25, 8'd25}, '{8'd8, 8'd4, 8'd3}, '{8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd16, 8'd255}, '{8'd5, 8'd255, 8'd1}, '{8'd1, 8'd3, 8'd2}};

  function automatic int unsigned geom(logic [7:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void store_cell(int unsigned a, logic [15:0] v);
    if (a < CELLS) screen[a] = v;
  endfunction

  function automatic void advance_row();
    int unsigned c = geom(ncols), r = geom(nbuf), keep;
    if (cur_row + 1 < r) begin
      cur_row = cur_row + 1;
    end else begin
      keep = (r - 1) * c;
      for (int unsigned i = 0; i < keep; i++)
        store_cell(i, (i + c < CELLS) ? screen[i + c] : 16'h0);
      for (int unsigned i = 0; i < c; i++) store_cell(keep + i, 16'h0);
    end
    cur_col = 0;
  endfunction

  function automatic out_t console_step(in_t w);
    out_t o;
    int unsigned c = geom(ncols), vis = geom(nvis);
    o = '0;
    case (w.operation)
      OP_PUT_ADV: begin
        if (w.character == NEWLINE_CHAR) begin
          advance_row();
        end else begin
          store_cell(cur_row * c + cur_col, {w.background, w.foreground, w.character});
          if (cur_col + 1 < c) cur_col = cur_col + 1;
          else advance_row();
        end
      end
      OP_PUT: store_cell(cur_row * c + cur_col, {w.background, w.foreground, w.character});
      OP_SET: begin
        cur_col = w.column;
        cur_row = w.row;
      end
      OP_CLEAR:
        for (int unsigned i = 0; i < vis * c; i++)
          store_cell(i, {w.background, WHITE, SPACE_CHAR});
      OP_READ: o.read_data = (w.cell_index < CELLS) ? screen[w.cell_index] : 16'h0;
      default: ;
    endcase
    o.cursor_column = cur_col;
    o.cursor_row = cur_row;
    if (cur_row >= vis) o.viewport_start = 12'((cur_row - vis) * c);
    return o;
  endfunction

  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) expected_words.push_back(console_step(in_word_i));
    if (out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %h", out_word_o);
        failed = 1'b1;
      end else begin
        out_t e;
        e = expected_words.pop_front();
        if (out_word_o.cursor_column !== e.cursor_column) begin
          $error("cursor_column exp %0d got %0d", e.cursor_column, out_word_o.cursor_column);
          failed = 1'b1;
        end
        if (out_word_o.cursor_row !== e.cursor_row) begin
          $error("cursor_row exp %0d got %0d", e.cursor_row, out_word_o.cursor_row);
          failed = 1'b1;
        end
        if (out_word_o.viewport_start !== e.viewport_start) begin
          $error("viewport_start exp %0d got %0d", e.viewport_start,
                 out_word_o.viewport_start);
          failed = 1'b1;
        end
        if (out_word_o.read_data !== e.read_data) begin
          $error("read_data exp %h got %h", e.read_data, out_word_o.read_data);
          failed = 1'b1;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if (!rst_ni || (in_valid_i && !in_taken)) begin
    end else if (hold_send || pending_words.size() == 0
                 || $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
    end else begin
      in_word_i <= pending_words.pop_front();
      in_valid_i <= 1'b1;
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_COLUMNS: ncols = v;
      CFG_BUFFER_ROWS: nbuf = v;
      default: nvis = v;
    endcase
  endtask

  function automatic in_t rand_word(logic [7:0] c, logic [7:0] r);
    in_t w;
    int unsigned k = $urandom_range(99);
    w = in_t'(IN_W'({$urandom, $urandom}));
    if (k < 55) w.operation = OP_PUT_ADV;
    else if (k < 65) w.operation = OP_PUT;
    else if (k < 77) w.operation = OP_SET;
    else if (k < 80) w.operation = OP_CLEAR;
    else if (k < 97) w.operation = OP_READ;
    else w.operation = 3'($urandom_range(5, 7));
    if (w.operation == OP_PUT_ADV && $urandom_range(9) == 0) w.character = NEWLINE_CHAR;
    if (w.operation == OP_SET && $urandom_range(3) != 0) begin
      w.column = 8'($urandom_range(geom(c)));
      w.row = 8'($urandom_range(geom(r)));
    end
    if (w.operation == OP_READ && $urandom_range(3) != 0)
      w.cell_index = 12'($urandom_range(geom(c) * geom(r)));
    return w;
  endfunction

  initial begin
    in_t w;
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
    cur_col = 0; cur_row = 0; ncols = 80; nbuf = 25; nvis = 25;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    w = '0;
    w.background = 4'h3; w.foreground = 4'hC;
    w.operation = OP_PUT_ADV; w.character = 8'h00; pending_words.push_back(w);
    w.character = 8'hFF; w.background = 4'hF; w.foreground = 4'h0; pending_words.push_back(w);
    w.character = NEWLINE_CHAR; pending_words.push_back(w);
    w.operation = OP_PUT; pending_words.push_back(w);
    w.operation = OP_SET; w.column = 8'd79; w.row = 8'd24; pending_words.push_back(w);
    w.operation = OP_PUT_ADV; w.character = 8'h5A; pending_words.push_back(w);
    w.operation = OP_SET; w.column = 8'hFF; w.row = 8'hFF; pending_words.push_back(w);
    w.operation = OP_PUT_ADV; pending_words.push_back(w);
    w.operation = OP_PUT; pending_words.push_back(w);
    w.operation = OP_READ; w.cell_index = 12'hFFF; pending_words.push_back(w);
    w.cell_index = 12'd0; pending_words.push_back(w);
    w.cell_index = 12'd1920; pending_words.push_back(w);
    w.operation = OP_CLEAR; w.background = 4'hA; pending_words.push_back(w);
    w.operation = OP_READ; w.cell_index = 12'd1999; pending_words.push_back(w);
    w.operation = 3'd5; pending_words.push_back(w);
    w.operation = 3'd7; pending_words.push_back(w);
    w.operation = OP_SET; w.column = 8'd0; w.row = 8'd0; pending_words.push_back(w);

    hold_send = 1'b1;
    repeat (30) @(posedge clk_i);
    hold_send = 1'b0;
    drain();

    for (int s = 0; s < 6; s++) begin
      for (int r = 0; r < 3; r++) write_reg(2'(r), cfg_sets[s][r]);
      send_idle_pct = (s < 2) ? 19 : (s < 4) ? 49 : 0;
      recv_idle_pct = (s < 2) ? 49 : (s < 4) ? 19 : 0;
      for (int n = 0; n < 255; n++) begin
        if (n == 128) begin
          wait (pending_words.size() == 0);
          hold_send = 1'b1;
          wait (expected_words.size() == 0 && !in_valid_i);
          hold_send = 1'b0;
        end
        pending_words.push_back(rand_word(cfg_sets[s][0], cfg_sets[s][1]));
      end
      drain();
    end

    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
